FILE: sv/sgi_pkg.sv
// Shared widths and the divider stage record for the segment intersection unit.
package sgi_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int ACC_W     = MAG_W + 2;
  localparam int Q_W       = COORD_W;
  localparam int DIV_STEPS = Q_W;
  localparam int SUM_W     = COORD_W + 2;

  typedef struct packed {
    logic                      hit;
    logic                      neg_x;
    logic                      neg_y;
    logic [MAG_W-1:0]          den;
    logic [MAG_W-1:0]          num;
    logic [Q_W-1:0]            mul_x;
    logic [Q_W-1:0]            mul_y;
    logic [MAG_W-1:0]          rem_x;
    logic [MAG_W-1:0]          rem_y;
    logic [Q_W-1:0]            q_x;
    logic [Q_W-1:0]            q_y;
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
  } div_t;

endpackage

FILE: sv/sgi_div_step.sv
// One registered step of the scaled divider: floor(num * mul / den), one multiplier bit per step.
module sgi_div_step (
  input  logic          clk,
  input  logic          load,
  input  sgi_pkg::div_t din,
  output sgi_pkg::div_t dout
);

  function automatic logic [sgi_pkg::MAG_W+sgi_pkg::Q_W-1:0] lane_step(
    input logic [sgi_pkg::MAG_W-1:0] rem,
    input logic [sgi_pkg::MAG_W-1:0] num,
    input logic [sgi_pkg::MAG_W-1:0] den,
    input logic                      b,
    input logic [sgi_pkg::Q_W-1:0]   q
  );
    logic [sgi_pkg::ACC_W:0]   acc;
    logic [sgi_pkg::ACC_W:0]   sub1;
    logic [sgi_pkg::ACC_W:0]   sub2;
    logic [sgi_pkg::MAG_W-1:0] r;
    logic [sgi_pkg::Q_W-1:0]   qs;
    logic [sgi_pkg::Q_W-1:0]   qn;
    acc  = {2'b00, rem, 1'b0} + (b ? {3'b000, num} : '0);
    sub1 = acc - {3'b000, den};
    sub2 = acc - {2'b00, den, 1'b0};
    qs   = {q[sgi_pkg::Q_W-2:0], 1'b0};
    if (!sub2[sgi_pkg::ACC_W]) begin
      r  = sub2[sgi_pkg::MAG_W-1:0];
      qn = qs + {{(sgi_pkg::Q_W-2){1'b0}}, 2'b10};
    end else if (!sub1[sgi_pkg::ACC_W]) begin
      r  = sub1[sgi_pkg::MAG_W-1:0];
      qn = qs | {{(sgi_pkg::Q_W-1){1'b0}}, 1'b1};
    end else begin
      r  = acc[sgi_pkg::MAG_W-1:0];
      qn = qs;
    end
    return {r, qn};
  endfunction

  sgi_pkg::div_t dnext;

  always_comb begin
    dnext = din;
    {dnext.rem_x, dnext.q_x} = lane_step(din.rem_x, din.num, din.den,
                                         din.mul_x[sgi_pkg::Q_W-1], din.q_x);
    {dnext.rem_y, dnext.q_y} = lane_step(din.rem_y, din.num, din.den,
                                         din.mul_y[sgi_pkg::Q_W-1], din.q_y);
    dnext.mul_x = {din.mul_x[sgi_pkg::Q_W-2:0], 1'b0};
    dnext.mul_y = {din.mul_y[sgi_pkg::Q_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= dnext;
    end
  end

endmodule

FILE: sv/segment_intersection_unit.sv
// Top level: pipelined 2-D segment intersection test with exact cross products and point.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   input   | in_valid / in_stall    | a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
//   output  | out_valid / out_stall  | hit, cross_x, cross_y
//
// One transaction per cycle unless out_stall backs the pipe up; stages: difference, product, cross, decision,
// sixteen divider steps (one quotient digit each) and the saturating output register.
// Every stage holds its own valid bit; a stage loads whenever it or any later stage
// is empty, so bubbles close up under out_stall and nothing is lost or repeated.
// rst is synchronous and clears the valid bits only.
module segment_intersection_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sgi_pkg::COORD_W-1:0] a_start_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] a_start_y,
  input  logic signed [sgi_pkg::COORD_W-1:0] a_end_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] a_end_y,
  input  logic signed [sgi_pkg::COORD_W-1:0] b_start_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] b_start_y,
  input  logic signed [sgi_pkg::COORD_W-1:0] b_end_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] b_end_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic signed [sgi_pkg::COORD_W-1:0] cross_x,
  output logic signed [sgi_pkg::COORD_W-1:0] cross_y
);

  localparam int DIV0 = 4;
  localparam int NST  = DIV0 + sgi_pkg::DIV_STEPS + 1;

  typedef struct packed {
    logic                               shared;
    logic signed [sgi_pkg::DIFF_W-1:0]  dax;
    logic signed [sgi_pkg::DIFF_W-1:0]  day;
    logic signed [sgi_pkg::DIFF_W-1:0]  dbx;
    logic signed [sgi_pkg::DIFF_W-1:0]  dby;
    logic signed [sgi_pkg::DIFF_W-1:0]  vx;
    logic signed [sgi_pkg::DIFF_W-1:0]  vy;
    logic signed [sgi_pkg::COORD_W-1:0] org_x;
    logic signed [sgi_pkg::COORD_W-1:0] org_y;
  } diff_t;

  typedef struct packed {
    logic                               shared;
    logic signed [sgi_pkg::PROD_W-1:0]  p_d0;
    logic signed [sgi_pkg::PROD_W-1:0]  p_d1;
    logic signed [sgi_pkg::PROD_W-1:0]  p_n10;
    logic signed [sgi_pkg::PROD_W-1:0]  p_n11;
    logic signed [sgi_pkg::PROD_W-1:0]  p_n20;
    logic signed [sgi_pkg::PROD_W-1:0]  p_n21;
    logic signed [sgi_pkg::DIFF_W-1:0]  dax;
    logic signed [sgi_pkg::DIFF_W-1:0]  day;
    logic signed [sgi_pkg::COORD_W-1:0] org_x;
    logic signed [sgi_pkg::COORD_W-1:0] org_y;
  } prod_t;

  typedef struct packed {
    logic                               shared;
    logic signed [sgi_pkg::CROSS_W-1:0] d;
    logic signed [sgi_pkg::CROSS_W-1:0] n1;
    logic signed [sgi_pkg::CROSS_W-1:0] n2;
    logic signed [sgi_pkg::DIFF_W-1:0]  dax;
    logic signed [sgi_pkg::DIFF_W-1:0]  day;
    logic signed [sgi_pkg::COORD_W-1:0] org_x;
    logic signed [sgi_pkg::COORD_W-1:0] org_y;
  } crs_t;

  function automatic logic signed [sgi_pkg::COORD_W-1:0] place(
    input logic signed [sgi_pkg::COORD_W-1:0] org,
    input logic [sgi_pkg::Q_W-1:0]            q,
    input logic                               neg
  );
    logic signed [sgi_pkg::SUM_W-1:0]   sum;
    logic signed [sgi_pkg::SUM_W-1:0]   qe;
    logic signed [sgi_pkg::SUM_W-1:0]   hi;
    logic signed [sgi_pkg::SUM_W-1:0]   lo;
    logic signed [sgi_pkg::COORD_W-1:0] res;
    qe  = {2'b00, q};
    hi  = {3'b000, {(sgi_pkg::COORD_W-1){1'b1}}};
    lo  = {3'b111, {(sgi_pkg::COORD_W-1){1'b0}}};
    sum = {{2{org[sgi_pkg::COORD_W-1]}}, org} + (neg ? -qe : qe);
    if (sum > hi) begin
      res = hi[sgi_pkg::COORD_W-1:0];
    end else if (sum < lo) begin
      res = lo[sgi_pkg::COORD_W-1:0];
    end else begin
      res = sum[sgi_pkg::COORD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic in_unit(
    input logic signed [sgi_pkg::CROSS_W-1:0] n,
    input logic signed [sgi_pkg::CROSS_W-1:0] d
  );
    logic ok;
    if (!d[sgi_pkg::CROSS_W-1]) begin
      ok = !n[sgi_pkg::CROSS_W-1] && (n <= d);
    end else begin
      ok = (n[sgi_pkg::CROSS_W-1] || (n == '0)) && (n >= d);
    end
    return ok;
  endfunction

  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;
  logic [NST-1:0] vld_in;

  diff_t         s1, s1_next;
  prod_t         s2, s2_next;
  crs_t          s3, s3_next;
  sgi_pkg::div_t s4, s4_next;
  sgi_pkg::div_t div_in  [sgi_pkg::DIV_STEPS];
  sgi_pkg::div_t div_out [sgi_pkg::DIV_STEPS];
  sgi_pkg::div_t last;

  logic signed [sgi_pkg::COORD_W-1:0] px_next;
  logic signed [sgi_pkg::COORD_W-1:0] py_next;
  logic signed [sgi_pkg::CROSS_W-1:0] abs_d;
  logic signed [sgi_pkg::CROSS_W-1:0] abs_n1;
  logic signed [sgi_pkg::DIFF_W-1:0]  abs_dax;
  logic signed [sgi_pkg::DIFF_W-1:0]  abs_day;

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_rdy
      assign rdy[k] = !out_stall || !(&vld[NST-1:k]);
    end
  endgenerate

  assign in_stall  = !rdy[0];
  assign out_valid = vld[NST-1];
  assign vld_in    = {vld[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  // differences and shared-endpoint check
  always_comb begin
    s1_next.shared = ((a_start_x == b_end_x) && (a_start_y == b_end_y)) ||
                     ((a_end_x == b_start_x) && (a_end_y == b_start_y));
    s1_next.dax    = {a_end_x[sgi_pkg::COORD_W-1], a_end_x} -
                     {a_start_x[sgi_pkg::COORD_W-1], a_start_x};
    s1_next.day    = {a_end_y[sgi_pkg::COORD_W-1], a_end_y} -
                     {a_start_y[sgi_pkg::COORD_W-1], a_start_y};
    s1_next.dbx    = {b_end_x[sgi_pkg::COORD_W-1], b_end_x} -
                     {b_start_x[sgi_pkg::COORD_W-1], b_start_x};
    s1_next.dby    = {b_end_y[sgi_pkg::COORD_W-1], b_end_y} -
                     {b_start_y[sgi_pkg::COORD_W-1], b_start_y};
    s1_next.vx     = {b_start_x[sgi_pkg::COORD_W-1], b_start_x} -
                     {a_start_x[sgi_pkg::COORD_W-1], a_start_x};
    s1_next.vy     = {b_start_y[sgi_pkg::COORD_W-1], b_start_y} -
                     {a_start_y[sgi_pkg::COORD_W-1], a_start_y};
    s1_next.org_x  = a_start_x;
    s1_next.org_y  = a_start_y;
  end

  // six products
  always_comb begin
    s2_next.shared = s1.shared;
    s2_next.p_d0   = s1.dax * s1.dby;
    s2_next.p_d1   = s1.day * s1.dbx;
    s2_next.p_n10  = s1.vx * s1.dby;
    s2_next.p_n11  = s1.vy * s1.dbx;
    s2_next.p_n20  = s1.vx * s1.day;
    s2_next.p_n21  = s1.vy * s1.dax;
    s2_next.dax    = s1.dax;
    s2_next.day    = s1.day;
    s2_next.org_x  = s1.org_x;
    s2_next.org_y  = s1.org_y;
  end

  // cross products
  always_comb begin
    s3_next.shared = s2.shared;
    s3_next.d      = {s2.p_d0[sgi_pkg::PROD_W-1], s2.p_d0} -
                     {s2.p_d1[sgi_pkg::PROD_W-1], s2.p_d1};
    s3_next.n1     = {s2.p_n10[sgi_pkg::PROD_W-1], s2.p_n10} -
                     {s2.p_n11[sgi_pkg::PROD_W-1], s2.p_n11};
    s3_next.n2     = {s2.p_n20[sgi_pkg::PROD_W-1], s2.p_n20} -
                     {s2.p_n21[sgi_pkg::PROD_W-1], s2.p_n21};
    s3_next.dax    = s2.dax;
    s3_next.day    = s2.day;
    s3_next.org_x  = s2.org_x;
    s3_next.org_y  = s2.org_y;
  end

  // decision, magnitudes and quotient signs
  always_comb begin
    abs_d   = s3.d[sgi_pkg::CROSS_W-1] ? -s3.d : s3.d;
    abs_n1  = s3.n1[sgi_pkg::CROSS_W-1] ? -s3.n1 : s3.n1;
    abs_dax = s3.dax[sgi_pkg::DIFF_W-1] ? -s3.dax : s3.dax;
    abs_day = s3.day[sgi_pkg::DIFF_W-1] ? -s3.day : s3.day;
    s4_next.hit   = !s3.shared && (s3.d != '0) &&
                    in_unit(s3.n1, s3.d) && in_unit(s3.n2, s3.d);
    s4_next.neg_x = s3.n1[sgi_pkg::CROSS_W-1] ^ s3.dax[sgi_pkg::DIFF_W-1] ^
                    s3.d[sgi_pkg::CROSS_W-1];
    s4_next.neg_y = s3.n1[sgi_pkg::CROSS_W-1] ^ s3.day[sgi_pkg::DIFF_W-1] ^
                    s3.d[sgi_pkg::CROSS_W-1];
    s4_next.den   = abs_d[sgi_pkg::MAG_W-1:0];
    s4_next.num   = abs_n1[sgi_pkg::MAG_W-1:0];
    s4_next.mul_x = abs_dax[sgi_pkg::Q_W-1:0];
    s4_next.mul_y = abs_day[sgi_pkg::Q_W-1:0];
    s4_next.rem_x = '0;
    s4_next.rem_y = '0;
    s4_next.q_x   = '0;
    s4_next.q_y   = '0;
    s4_next.org_x = s3.org_x;
    s4_next.org_y = s3.org_y;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1 <= s1_next;
    end
    if (rdy[1]) begin
      s2 <= s2_next;
    end
    if (rdy[2]) begin
      s3 <= s3_next;
    end
    if (rdy[3]) begin
      s4 <= s4_next;
    end
  end

  generate
    for (k = 0; k < sgi_pkg::DIV_STEPS; k++) begin : g_div
      if (k == 0) begin : g_first
        assign div_in[k] = s4;
      end else begin : g_next
        assign div_in[k] = div_out[k-1];
      end
      sgi_div_step u_step (
        .clk  (clk),
        .load (rdy[DIV0+k]),
        .din  (div_in[k]),
        .dout (div_out[k])
      );
    end
  endgenerate

  assign last = div_out[sgi_pkg::DIV_STEPS-1];

  always_comb begin
    px_next = last.hit ? place(last.org_x, last.q_x, last.neg_x) : '0;
    py_next = last.hit ? place(last.org_y, last.q_y, last.neg_y) : '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      hit     <= last.hit;
      cross_x <= px_next;
      cross_y <= py_next;
    end
  end

endmodule

FILE: tb/segment_intersection_checker.sv
// Checker for the segment intersection unit: predicts each result and compares it.
`timescale 1ns / 100ps

module segment_intersection_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [sgi_pkg::COORD_W-1:0] a_start_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] a_start_y,
  input  logic signed [sgi_pkg::COORD_W-1:0] a_end_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] a_end_y,
  input  logic signed [sgi_pkg::COORD_W-1:0] b_start_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] b_start_y,
  input  logic signed [sgi_pkg::COORD_W-1:0] b_end_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] b_end_y,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               hit,
  input  logic signed [sgi_pkg::COORD_W-1:0] cross_x,
  input  logic signed [sgi_pkg::COORD_W-1:0] cross_y,
  output int                                 fail_count,
  output int                                 pending
);

  typedef logic signed [sgi_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    logic   hit;
    coord_t x;
    coord_t y;
  } meet_t;

  localparam longint COORD_MAX = (longint'(1) <<< (sgi_pkg::COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (sgi_pkg::COORD_W - 1));

  meet_t expected_meets[$];
  int    mismatches = 0;
  int    queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  function automatic bit within_unit(longint n, longint d);
    if (d > 0) return (n >= 0) && (n <= d);
    return (n <= 0) && (n >= d);
  endfunction

  function automatic coord_t saturate(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic meet_t predict_meet(coord_t asx, coord_t asy, coord_t aex, coord_t aey,
                                         coord_t bsx, coord_t bsy, coord_t bex, coord_t bey);
    meet_t  r;
    longint dax, day, dbx, dby, vx, vy, d, n1, n2;
    r = '0;
    if ((asx == bex && asy == bey) || (aex == bsx && aey == bsy)) return r;
    dax = longint'(aex) - longint'(asx);
    day = longint'(aey) - longint'(asy);
    dbx = longint'(bex) - longint'(bsx);
    dby = longint'(bey) - longint'(bsy);
    vx  = longint'(bsx) - longint'(asx);
    vy  = longint'(bsy) - longint'(asy);
    d   = dax * dby - day * dbx;
    if (d == 0) return r;
    n1 = vx * dby - vy * dbx;
    n2 = vx * day - vy * dax;
    if (!within_unit(n1, d) || !within_unit(n2, d)) return r;
    r.hit = 1'b1;
    r.x   = saturate(longint'(asx) + (n1 * dax) / d);
    r.y   = saturate(longint'(asy) + (n1 * day) / d);
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    meet_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_meets = {expected_meets,
                          predict_meet(a_start_x, a_start_y, a_end_x, a_end_y,
                                       b_start_x, b_start_y, b_end_x, b_end_y)};
      if (out_valid && !out_stall) begin
        if (expected_meets.size() == 0) begin
          report_mismatch("unexpected transaction hit", hit, 0);
        end else begin
          want = expected_meets[0];
          expected_meets.delete(0);
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (cross_x !== want.x) report_mismatch("cross_x", cross_x, want.x);
          if (cross_y !== want.y) report_mismatch("cross_y", cross_y, want.y);
        end
      end
      queued <= expected_meets.size();
    end
  end

endmodule

FILE: tb/segment_intersection_unit_tb.sv
// Testbench top for the segment intersection unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module segment_intersection_unit_tb;

  typedef logic signed [sgi_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t asx, asy, aex, aey;
    coord_t bsx, bsy, bex, bey;
  } seg_pair_t;

  localparam longint COORD_MAX  = (longint'(1) <<< (sgi_pkg::COORD_W - 1)) - 1;
  localparam longint COORD_MIN  = -(longint'(1) <<< (sgi_pkg::COORD_W - 1));
  localparam int     LONG_HOLD  = 300;
  localparam int     DRAIN_WAIT = 30;
  localparam int     QUIET_MAX  = 2000;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
  coord_t b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   hit;
  coord_t cross_x, cross_y;

  int fail_count;
  int pending;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  segment_intersection_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_start_x(a_start_x), .a_start_y(a_start_y), .a_end_x(a_end_x), .a_end_y(a_end_y),
    .b_start_x(b_start_x), .b_start_y(b_start_y), .b_end_x(b_end_x), .b_end_y(b_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .cross_x(cross_x), .cross_y(cross_y)
  );

  segment_intersection_checker intersect_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_start_x(a_start_x), .a_start_y(a_start_y), .a_end_x(a_end_x), .a_end_y(a_end_y),
    .b_start_x(b_start_x), .b_start_y(b_start_y), .b_end_x(b_end_x), .b_end_y(b_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .cross_x(cross_x), .cross_y(cross_y),
    .fail_count(fail_count), .pending(pending)
  );

  // result side: random stall bursts, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      hold_left <= $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic coord_t clip(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic longint rnd(int bits);
    return longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
  endfunction

  function automatic seg_pair_t seg(longint asx, longint asy, longint aex, longint aey,
                                    longint bsx, longint bsy, longint bex, longint bey);
    seg_pair_t p;
    p.asx = clip(asx); p.asy = clip(asy); p.aex = clip(aex); p.aey = clip(aey);
    p.bsx = clip(bsx); p.bsy = clip(bsy); p.bex = clip(bex); p.bey = clip(bey);
    return p;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int        sel, bits, k, k2;
    longint    asx, asy, aex, aey, px, py, wx, wy, bsx, bsy;
    sel  = $urandom_range(0, 99);
    bits = $urandom_range(1, 16);
    p = seg(rnd(bits), rnd(bits), rnd(bits), rnd(bits),
            rnd(bits), rnd(bits), rnd(bits), rnd(bits));
    if (sel < 45) begin
      // B built through a point on A
      bits = $urandom_range(2, 14);
      asx = rnd(bits); asy = rnd(bits); aex = rnd(bits); aey = rnd(bits);
      k   = $urandom_range(0, 16);
      px  = asx + (aex - asx) * k / 16;
      py  = asy + (aey - asy) * k / 16;
      wx  = rnd(bits); wy = rnd(bits);
      k2  = $urandom_range(0, 16);
      bsx = px - wx * k2 / 16;
      bsy = py - wy * k2 / 16;
      p = seg(asx, asy, aex, aey, bsx, bsy, bsx + wx, bsy + wy);
    end else if (sel < 70) begin
      // uniform at a random scale, already in p
    end else if (sel < 80) begin
      p = seg(rnd(16), rnd(16), rnd(16), rnd(16), rnd(16), rnd(16), rnd(16), rnd(16));
    end else if (sel < 88) begin
      if ($urandom_range(0, 1) == 0) begin
        p.bex = p.asx; p.bey = p.asy;
      end else begin
        p.bsx = p.aex; p.bsy = p.aey;
      end
    end else if (sel < 95) begin
      k = $urandom_range(0, 1) == 0 ? 1 : -1;
      p.bex = clip(longint'(p.bsx) + k * (longint'(p.aex) - longint'(p.asx)));
      p.bey = clip(longint'(p.bsy) + k * (longint'(p.aey) - longint'(p.asy)));
    end else begin
      p.bsx = p.asx; p.bsy = p.asy;
    end
    return p;
  endfunction

  task automatic send_pair(input seg_pair_t p);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    a_start_x <= p.asx; a_start_y <= p.asy; a_end_x <= p.aex; a_end_y <= p.aey;
    b_start_x <= p.bsx; b_start_y <= p.bsy; b_end_x <= p.bex; b_end_y <= p.bey;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    longint hi, lo;
    hi = COORD_MAX;
    lo = COORD_MIN;
    repeat (4) @(posedge clk);
    rst     <= 1'b0;
    tx_gaps <= 1'b1;
    rx_gaps <= 1'b1;

    send_pair(seg(-160, -160, 160, 160, -160, 160, 160, -160));
    send_pair(seg(160, 160, -160, -160, -160, 160, 160, -160));
    send_pair(seg(0, 0, 320, 320, 480, 0, 0, 0));        // A start on B end
    send_pair(seg(0, 0, 320, 320, 320, 320, 640, 0));    // A end on B start
    send_pair(seg(0, 0, 100, 0, 0, 50, 100, 50));        // parallel
    send_pair(seg(0, 0, 100, 0, 50, 0, 200, 0));         // collinear overlap
    send_pair(seg(30, 30, 30, 30, 0, 0, 60, 60));        // A is a point
    send_pair(seg(5, 5, 5, 5, 9, 9, 9, 9));              // both points
    send_pair(seg(0, 0, 100, 0, 0, -50, 0, 50));         // t1 = 0
    send_pair(seg(0, 0, 100, 0, 100, -50, 100, 50));     // t1 = 1
    send_pair(seg(0, 0, 100, 0, 50, 0, 50, 60));         // t2 = 0
    send_pair(seg(0, 0, 100, 0, 50, 60, 50, 0));         // t2 = 1
    send_pair(seg(0, 0, 100, 0, 150, -50, 150, 50));
    send_pair(seg(0, 0, 100, 0, -10, -50, -10, 50));
    send_pair(seg(0, 0, 100, 0, 50, 10, 50, 60));
    send_pair(seg(0, 0, 100, 0, 50, -60, 50, -1));
    send_pair(seg(0, 0, 300, 7, 1, -50, 13, 41));        // truncated quotient
    send_pair(seg(0, 0, -300, -7, -1, 50, -13, -41));    // negative quotient
    send_pair(seg(lo, lo, hi, hi, lo, hi, hi, lo));
    send_pair(seg(hi, lo, lo, hi, lo, lo, hi, hi));
    send_pair(seg(lo, lo, lo, lo, lo, lo, lo, lo));
    send_pair(seg(hi, hi, hi, hi, hi, hi, hi, hi));
    send_pair(seg(lo, hi, hi, lo, hi, hi, lo, lo));
    send_pair(seg(-1, -1, 0, 0, 0, -1, -1, 0));
    drain();

    // hold results back while transactions keep coming, so the pipe backs up
    tx_gaps  <= 1'b0;
    hold_req <= hold_req + 1;
    repeat (60) send_pair(random_pair());
    drain();

    for (int i = 0; i < 600; i++) begin
      if (i == 300) drain();
      if (i % 150 == 0) begin
        tx_gaps <= (i != 150);
        rx_gaps <= (i != 450);
      end
      send_pair(random_pair());
    end

    tx_gaps <= 1'b0;
    rx_gaps <= 1'b0;
    repeat (140) send_pair(random_pair());
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
